### sv/fds_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the F-LOOK disk scheduler.
// No dependencies.
package fds_pkg;

   localparam int QUEUE_DEPTH = 32;
   localparam int TRACK_BITS  = 16;
   localparam int ID_BITS     = 16;
   localparam int SLOT_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   typedef enum logic {
      REQ_ADD   = 1'b0,
      REQ_ISSUE = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      RSP_ADDED   = 2'd0,
      RSP_ISSUED  = 2'd1,
      RSP_EMPTY   = 2'd2,
      RSP_DROPPED = 2'd3
   } rsp_status_type;

   typedef enum logic [3:0] {
      FSM_IDLE   = 4'b0001,
      FSM_SCAN   = 4'b0010,
      FSM_DRAIN  = 4'b0100,
      FSM_FINISH = 4'b1000
   } fsm_state_type;

   typedef struct packed {
      logic [TRACK_BITS-1:0] track;
      logic [ID_BITS-1:0]    id;
   } slot_entry_type;

   // controller -> picker
   typedef struct packed {
      logic                  clear;
      logic                  sample;
      logic                  dir_down;
      logic [TRACK_BITS-1:0] head;
      logic [SLOT_BITS-1:0]  slot;
   } pick_ctrl_type;

   // picker -> controller
   typedef struct packed {
      logic                  flip;
      logic [SLOT_BITS-1:0]  slot;
      logic [TRACK_BITS-1:0] track;
      logic [ID_BITS-1:0]    id;
   } pick_result_type;

endpackage

### sv/fds_req_if.sv
`timescale 1ns / 1ps
// Request channel: valid/ready handshake with add/issue payload.
// Depends on fds_pkg.
interface fds_req_if;
   logic                           valid;
   logic                           ready;
   logic                           req_type;
   logic [fds_pkg::TRACK_BITS-1:0] req_track;
   logic [fds_pkg::ID_BITS-1:0]    req_id;
   logic [fds_pkg::TRACK_BITS-1:0] head_track;

   modport source (output valid, req_type, req_track, req_id, head_track, input ready);
   modport sink   (input valid, req_type, req_track, req_id, head_track, output ready);
   modport monitor (input valid, ready, req_type, req_track, req_id, head_track);
endinterface

### sv/fds_rsp_if.sv
`timescale 1ns / 1ps
// Response channel: valid/ready handshake with status and issued request.
// Depends on fds_pkg.
interface fds_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     status;
   logic [fds_pkg::TRACK_BITS-1:0] issued_track;
   logic [fds_pkg::ID_BITS-1:0]    issued_id;
   logic                           sweep_down;

   modport source (output valid, status, issued_track, issued_id, sweep_down, input ready);
   modport sink   (input valid, status, issued_track, issued_id, sweep_down, output ready);
   modport monitor (input valid, ready, status, issued_track, issued_id, sweep_down);
endinterface

### sv/fds_slot_ram.sv
`timescale 1ns / 1ps
// Slot store: track and id per slot, one write and one registered read port.
// Depends on fds_pkg.
module fds_slot_ram (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [fds_pkg::SLOT_BITS-1:0] wr_addr,
   input  fds_pkg::slot_entry_type       wr_data,
   input  logic                          rd_en,
   input  logic [fds_pkg::SLOT_BITS-1:0] rd_addr,
   output fds_pkg::slot_entry_type       rd_data
);

   fds_pkg::slot_entry_type mem [fds_pkg::QUEUE_DEPTH];
   fds_pkg::slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/fds_pick.sv
`timescale 1ns / 1ps
// Nearest-request picker: keeps the best candidate in the current sweep
// direction and in the reversed one while the slots stream by. Depends on fds_pkg.
module fds_pick (
   input  logic                    clock,
   input  logic                    reset,
   input  fds_pkg::pick_ctrl_type  ctrl,
   input  fds_pkg::slot_entry_type data,
   output fds_pkg::pick_result_type result
);

   logic                           fwd_found_ff, fwd_found_in;
   logic                           rev_found_ff, rev_found_in;
   logic [fds_pkg::TRACK_BITS-1:0] fwd_dist_ff, fwd_dist_in, rev_dist_ff, rev_dist_in;
   logic [fds_pkg::SLOT_BITS-1:0]  fwd_slot_ff, fwd_slot_in, rev_slot_ff, rev_slot_in;
   fds_pkg::slot_entry_type        fwd_ent_ff, fwd_ent_in, rev_ent_ff, rev_ent_in;

   logic                           is_below, is_above;
   logic [fds_pkg::TRACK_BITS-1:0] dist_up, dist_down, fwd_d, rev_d;
   logic                           fwd_ok, rev_ok, fwd_better, rev_better;

   always_comb begin
      // a request on the head track counts as ahead in both directions
      is_below  = data.track <= ctrl.head;
      is_above  = data.track >= ctrl.head;
      dist_up   = data.track - ctrl.head;
      dist_down = ctrl.head - data.track;
      fwd_ok    = ctrl.dir_down ? is_below : is_above;
      rev_ok    = ctrl.dir_down ? is_above : is_below;
      fwd_d     = ctrl.dir_down ? dist_down : dist_up;
      rev_d     = ctrl.dir_down ? dist_up : dist_down;

      // strict compares keep the lowest slot on a full tie
      fwd_better = !fwd_found_ff || (fwd_d < fwd_dist_ff) ||
                   ((fwd_d == fwd_dist_ff) && (data.id < fwd_ent_ff.id));
      rev_better = !rev_found_ff || (rev_d < rev_dist_ff) ||
                   ((rev_d == rev_dist_ff) && (data.id < rev_ent_ff.id));

      fwd_found_in = fwd_found_ff;
      fwd_dist_in  = fwd_dist_ff;
      fwd_slot_in  = fwd_slot_ff;
      fwd_ent_in   = fwd_ent_ff;
      rev_found_in = rev_found_ff;
      rev_dist_in  = rev_dist_ff;
      rev_slot_in  = rev_slot_ff;
      rev_ent_in   = rev_ent_ff;

      if (ctrl.clear) begin
         fwd_found_in = 1'b0;
         rev_found_in = 1'b0;
      end else if (ctrl.sample) begin
         if (fwd_ok && fwd_better) begin
            fwd_found_in = 1'b1;
            fwd_dist_in  = fwd_d;
            fwd_slot_in  = ctrl.slot;
            fwd_ent_in   = data;
         end
         if (rev_ok && rev_better) begin
            rev_found_in = 1'b1;
            rev_dist_in  = rev_d;
            rev_slot_in  = ctrl.slot;
            rev_ent_in   = data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_found_ff <= 1'b0;
         rev_found_ff <= 1'b0;
      end else begin
         fwd_found_ff <= fwd_found_in;
         rev_found_ff <= rev_found_in;
      end
      fwd_dist_ff <= fwd_dist_in;
      fwd_slot_ff <= fwd_slot_in;
      fwd_ent_ff  <= fwd_ent_in;
      rev_dist_ff <= rev_dist_in;
      rev_slot_ff <= rev_slot_in;
      rev_ent_ff  <= rev_ent_in;
   end

   // nothing ahead in the current direction: sweep reverses
   always_comb begin
      result.flip  = !fwd_found_ff;
      result.slot  = fwd_found_ff ? fwd_slot_ff : rev_slot_ff;
      result.track = fwd_found_ff ? fwd_ent_ff.track : rev_ent_ff.track;
      result.id    = fwd_found_ff ? fwd_ent_ff.id : rev_ent_ff.id;
   end

endmodule

### sv/flook_disk_scheduler_unit.sv
`timescale 1ns / 1ps
// F-LOOK disk request scheduler, top level: slot bookkeeping and scan control.
// Depends on fds_pkg, fds_req_if, fds_rsp_if, fds_slot_ram, fds_pick.
//
//   channel   dir  handshake     payload
//   req_chan  in   valid/ready   req_type, req_track, req_id, head_track
//   rsp_chan  out  valid/ready   status, issued_track, issued_id, sweep_down
//
// An add's response is registered at the accepting edge.
// An issue is answered after a scan: the scan state reads the slot RAM once per slot,
// the drain state takes the last read data, and the finish state retires the chosen slot.
// The block then returns to idle, where the next beat can be taken.
// An issue on an empty store is answered at the accepting edge.
// Synchronous reset clears valid bits, set bits, sweep direction and handshake.
// A new beat is taken when idle and the response register is empty or draining.
module flook_disk_scheduler_unit (
   input logic        clock,
   input logic        reset,
   fds_req_if.sink    req_chan,
   fds_rsp_if.source  rsp_chan
);

   localparam logic [fds_pkg::SLOT_BITS-1:0] LastSlot =
      fds_pkg::SLOT_BITS'(fds_pkg::QUEUE_DEPTH - 1);

   fds_pkg::fsm_state_type state_ff, state_in;

   logic [fds_pkg::QUEUE_DEPTH-1:0] valid_ff, valid_in;
   logic [fds_pkg::QUEUE_DEPTH-1:0] set_ff, set_in;
   logic                            active_ff, active_in;
   logic                            dir_ff, dir_in;
   logic [fds_pkg::TRACK_BITS-1:0]  head_ff, head_in;
   logic [fds_pkg::SLOT_BITS-1:0]   addr_ff, addr_in;
   logic                            rd_vld_ff, rd_vld_in;
   logic [fds_pkg::SLOT_BITS-1:0]   rd_slot_ff, rd_slot_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [1:0]                      rsp_status_ff, rsp_status_in;
   logic [fds_pkg::TRACK_BITS-1:0]  rsp_track_ff, rsp_track_in;
   logic [fds_pkg::ID_BITS-1:0]     rsp_id_ff, rsp_id_in;
   logic                            rsp_dir_ff, rsp_dir_in;

   logic [fds_pkg::QUEUE_DEPTH-1:0] act_mask;
   logic                            any_valid, any_active;
   logic                            free_hit;
   logic [fds_pkg::SLOT_BITS-1:0]   free_idx;
   logic                            accept;
   logic                            scan_start;

   logic                            wr_en, rd_en;
   fds_pkg::slot_entry_type         wr_data, rd_data;
   fds_pkg::pick_ctrl_type          pick_ctrl;
   fds_pkg::pick_result_type        pick_res;

   assign act_mask   = valid_ff & ~(set_ff ^ {fds_pkg::QUEUE_DEPTH{active_ff}});
   assign any_valid  = |valid_ff;
   assign any_active = |act_mask;

   // lowest free slot
   always_comb begin
      free_hit = 1'b0;
      free_idx = '0;
      for (int i = fds_pkg::QUEUE_DEPTH - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_hit = 1'b1;
            free_idx = fds_pkg::SLOT_BITS'(i);
         end
      end
   end

   assign req_chan.ready = (state_ff == fds_pkg::FSM_IDLE) &&
                           (!rsp_valid_ff || rsp_chan.ready);
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      set_in        = set_ff;
      active_in     = active_ff;
      dir_in        = dir_ff;
      head_in       = head_ff;
      addr_in       = addr_ff;
      rd_vld_in     = 1'b0;
      rd_slot_in    = addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_track_in  = rsp_track_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_dir_in    = rsp_dir_ff;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      wr_data.track = req_chan.req_track;
      wr_data.id    = req_chan.req_id;
      scan_start    = 1'b0;

      unique case (state_ff)
         fds_pkg::FSM_IDLE: begin
            if (accept) begin
               rsp_track_in = '0;
               rsp_id_in    = '0;
               rsp_dir_in   = dir_ff;
               if (req_chan.req_type == fds_pkg::REQ_ADD) begin
                  rsp_valid_in = 1'b1;
                  if (free_hit) begin
                     wr_en              = 1'b1;
                     valid_in[free_idx] = 1'b1;
                     set_in[free_idx]   = !active_ff;
                     rsp_status_in      = fds_pkg::RSP_ADDED;
                  end else begin
                     rsp_status_in = fds_pkg::RSP_DROPPED;
                  end
               end else if (!any_valid) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = fds_pkg::RSP_EMPTY;
               end else begin
                  // empty active set: pending becomes active
                  active_in       = any_active ? active_ff : !active_ff;
                  head_in         = req_chan.head_track;
                  addr_in         = '0;
                  scan_start      = 1'b1;
                  state_in        = fds_pkg::FSM_SCAN;
               end
            end
         end
         fds_pkg::FSM_SCAN: begin
            rd_en      = 1'b1;
            rd_vld_in  = 1'b1;
            rd_slot_in = addr_ff;
            if (addr_ff == LastSlot) begin
               state_in = fds_pkg::FSM_DRAIN;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         fds_pkg::FSM_DRAIN: begin
            state_in = fds_pkg::FSM_FINISH;
         end
         fds_pkg::FSM_FINISH: begin
            dir_in                 = dir_ff ^ pick_res.flip;
            valid_in[pick_res.slot] = 1'b0;
            rsp_valid_in           = 1'b1;
            rsp_status_in          = fds_pkg::RSP_ISSUED;
            rsp_track_in           = pick_res.track;
            rsp_id_in              = pick_res.id;
            rsp_dir_in             = dir_ff ^ pick_res.flip;
            state_in               = fds_pkg::FSM_IDLE;
         end
         default: begin
            state_in = fds_pkg::FSM_IDLE;
         end
      endcase
   end

   always_comb begin
      pick_ctrl.clear    = scan_start;
      pick_ctrl.sample   = rd_vld_ff && act_mask[rd_slot_ff];
      pick_ctrl.dir_down = dir_ff;
      pick_ctrl.head     = head_ff;
      pick_ctrl.slot     = rd_slot_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fds_pkg::FSM_IDLE;
         valid_ff     <= '0;
         set_ff       <= '0;
         active_ff    <= 1'b0;
         dir_ff       <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         set_ff       <= set_in;
         active_ff    <= active_in;
         dir_ff       <= dir_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      head_ff       <= head_in;
      addr_ff       <= addr_in;
      rd_slot_ff    <= rd_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_track_ff  <= rsp_track_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_dir_ff    <= rsp_dir_in;
   end

   // writes happen only on an idle add, reads only during a scan: no overlap
   fds_slot_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (free_idx),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   fds_pick u_pick (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (pick_ctrl),
      .data   (rd_data),
      .result (pick_res)
   );

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.issued_track = rsp_track_ff;
   assign rsp_chan.issued_id    = rsp_id_ff;
   assign rsp_chan.sweep_down   = rsp_dir_ff;

endmodule

### sv/fds_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the disk scheduler, bound to the top level.
// Depends on fds_pkg, fds_req_if, fds_rsp_if, flook_disk_scheduler_unit.
module fds_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           req_type,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [1:0]                     rsp_status,
   input logic [fds_pkg::TRACK_BITS-1:0] rsp_issued_track,
   input logic [fds_pkg::ID_BITS-1:0]    rsp_issued_id
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("stalled response changed");

   a_no_accept_when_blocked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while response blocked");

   a_add_answers_next: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_type == fds_pkg::REQ_ADD)
      |=> rsp_valid &&
          (rsp_status == fds_pkg::RSP_ADDED || rsp_status == fds_pkg::RSP_DROPPED))
      else $error("add not answered in one cycle");

   a_zero_when_not_issued: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != fds_pkg::RSP_ISSUED)
      |-> (rsp_issued_track == '0) && (rsp_issued_id == '0))
      else $error("nonzero request fields without issue");

endmodule

bind flook_disk_scheduler_unit fds_checker u_fds_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .req_type         (req_chan.req_type),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_status       (rsp_chan.status),
   .rsp_issued_track (rsp_chan.issued_track),
   .rsp_issued_id    (rsp_chan.issued_id)
);

### sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for flook_disk_scheduler_unit: directed and random add/issue beats,
// scored against an in-bench F-LOOK scheduler model. Depends on fds_pkg, fds_req_if,
// fds_rsp_if and the scheduler RTL.
module tb_top;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int ISSUE_CYCLES = fds_pkg::QUEUE_DEPTH + 3;
   localparam int RANDOM_BEATS = 1700;

   typedef struct packed {
      fds_pkg::req_kind_type          kind;
      logic [fds_pkg::TRACK_BITS-1:0] track;
      logic [fds_pkg::ID_BITS-1:0]    id;
      logic [fds_pkg::TRACK_BITS-1:0] head;
   } req_beat_type;

   typedef struct packed {
      fds_pkg::rsp_status_type        status;
      logic [fds_pkg::TRACK_BITS-1:0] track;
      logic [fds_pkg::ID_BITS-1:0]    id;
      logic                           down;
   } sched_result_type;

   logic clock;
   logic reset;

   fds_req_if req_chan ();
   fds_rsp_if rsp_chan ();

   flook_disk_scheduler_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // scheduler model state
   logic [fds_pkg::TRACK_BITS-1:0] slot_trk  [fds_pkg::QUEUE_DEPTH];
   logic [fds_pkg::ID_BITS-1:0]    slot_tag  [fds_pkg::QUEUE_DEPTH];
   bit                             slot_held [fds_pkg::QUEUE_DEPTH];
   bit                             slot_group[fds_pkg::QUEUE_DEPTH];
   bit                             live_group;
   bit                             sweeping_down;

   sched_result_type expected_rsp[$];

   int  err_count;
   int  cycle_count;
   int  status_seen[4];
   int  dir_changes;
   bit  last_down;
   bit  idle_en;
   int  rsp_hold_req;
   logic [fds_pkg::TRACK_BITS-1:0] cluster_base;
   logic [fds_pkg::TRACK_BITS-1:0] last_added_track;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------- model ----------------
   function automatic bit lies_ahead(input logic [fds_pkg::TRACK_BITS-1:0] t,
                                     input logic [fds_pkg::TRACK_BITS-1:0] h);
      return sweeping_down ? (t <= h) : (t >= h);
   endfunction

   function automatic int stored_count();
      int n;
      n = 0;
      for (int i = 0; i < fds_pkg::QUEUE_DEPTH; i++) n += slot_held[i];
      return n;
   endfunction

   function automatic sched_result_type schedule_step(input req_beat_type b);
      sched_result_type               r;
      int                             free_slot;
      int                             pick;
      bit                             any_held;
      bit                             any_live;
      bit                             any_ahead;
      logic [fds_pkg::TRACK_BITS-1:0] trk_gap;
      logic [fds_pkg::TRACK_BITS-1:0] best_gap;
      r.status  = fds_pkg::RSP_ADDED;
      r.track   = '0;
      r.id      = '0;
      free_slot = -1;
      pick      = -1;
      any_held  = 1'b0;
      any_live  = 1'b0;
      any_ahead = 1'b0;
      best_gap  = '0;
      if (b.kind == fds_pkg::REQ_ADD) begin
         for (int i = 0; i < fds_pkg::QUEUE_DEPTH; i++)
            if (!slot_held[i] && free_slot < 0) free_slot = i;
         if (free_slot < 0) begin
            r.status = fds_pkg::RSP_DROPPED;
         end else begin
            slot_trk[free_slot]   = b.track;
            slot_tag[free_slot]   = b.id;
            slot_held[free_slot]  = 1'b1;
            slot_group[free_slot] = ~live_group;
         end
      end else begin
         for (int i = 0; i < fds_pkg::QUEUE_DEPTH; i++) begin
            if (slot_held[i]) any_held = 1'b1;
            if (slot_held[i] && slot_group[i] == live_group) any_live = 1'b1;
         end
         if (!any_held) begin
            r.status = fds_pkg::RSP_EMPTY;
         end else begin
            if (!any_live) live_group = ~live_group;
            for (int i = 0; i < fds_pkg::QUEUE_DEPTH; i++)
               if (slot_held[i] && slot_group[i] == live_group &&
                   lies_ahead(slot_trk[i], b.head))
                  any_ahead = 1'b1;
            if (!any_ahead) sweeping_down = ~sweeping_down;
            for (int i = 0; i < fds_pkg::QUEUE_DEPTH; i++) begin
               if (slot_held[i] && slot_group[i] == live_group &&
                   lies_ahead(slot_trk[i], b.head)) begin
                  trk_gap = sweeping_down ? b.head - slot_trk[i] : slot_trk[i] - b.head;
                  if (pick < 0 || trk_gap < best_gap ||
                      (trk_gap == best_gap && slot_tag[i] < slot_tag[pick])) begin
                     pick     = i;
                     best_gap = trk_gap;
                  end
               end
            end
            r.status        = fds_pkg::RSP_ISSUED;
            r.track         = slot_trk[pick];
            r.id            = slot_tag[pick];
            slot_held[pick] = 1'b0;
         end
      end
      r.down = sweeping_down;
      return r;
   endfunction

   // ---------------- request side ----------------
   task automatic send_beat(input req_beat_type b, input int gap);
      if (gap > 0) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_chan.valid      <= 1'b1;
      req_chan.req_type   <= b.kind;
      req_chan.req_track  <= b.track;
      req_chan.req_id     <= b.id;
      req_chan.head_track <= b.head;
      do @(posedge clock); while (!req_chan.ready);
      expected_rsp.push_back(schedule_step(b));
   endtask

   task automatic hold_request();
      @(negedge clock);
      req_chan.valid <= 1'b0;
   endtask

   function automatic int next_gap();
      if (!idle_en) return 0;
      if ($urandom_range(0, 3) == 0) return $urandom_range(1, 10);
      return 0;
   endfunction

   function automatic req_beat_type make_beat(input fds_pkg::req_kind_type k,
                                              input int trk, input int tag, input int hd);
      req_beat_type b;
      b.kind  = k;
      b.track = trk[fds_pkg::TRACK_BITS-1:0];
      b.id    = tag[fds_pkg::ID_BITS-1:0];
      b.head  = hd[fds_pkg::TRACK_BITS-1:0];
      return b;
   endfunction

   task automatic add_req(input int trk, input int tag);
      send_beat(make_beat(fds_pkg::REQ_ADD, trk, tag, $urandom), next_gap());
   endtask

   task automatic issue_req(input int hd);
      send_beat(make_beat(fds_pkg::REQ_ISSUE, $urandom, $urandom, hd), next_gap());
   endtask

   function automatic req_beat_type random_beat(input int add_pct, input bit tight);
      req_beat_type b;
      b.kind  = ($urandom_range(0, 99) < add_pct) ? fds_pkg::REQ_ADD : fds_pkg::REQ_ISSUE;
      b.track = tight ? cluster_base + fds_pkg::TRACK_BITS'($urandom_range(0, 6))
                      : fds_pkg::TRACK_BITS'($urandom);
      b.id    = tight ? fds_pkg::ID_BITS'($urandom_range(0, 3))
                      : fds_pkg::ID_BITS'($urandom);
      case ($urandom_range(0, 5))
         0:       b.head = '0;
         1:       b.head = '1;
         2:       b.head = last_added_track;
         3:       b.head = cluster_base + fds_pkg::TRACK_BITS'($urandom_range(0, 6));
         default: b.head = fds_pkg::TRACK_BITS'($urandom);
      endcase
      if (b.kind == fds_pkg::REQ_ADD) last_added_track = b.track;
      return b;
   endfunction

   task automatic drain_results();
      hold_request();
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (ISSUE_CYCLES + 5) @(posedge clock);
   endtask

   // ---------------- response side ----------------
   initial begin : rsp_ready_driver
      int stall_left;
      stall_left     = 0;
      rsp_chan.ready = 1'b0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else if (rsp_hold_req > 0) begin
            // long hold-off so the block backs up into the request channel
            stall_left     = rsp_hold_req - 1;
            rsp_hold_req   = 0;
            rsp_chan.ready <= 1'b0;
         end else if (idle_en && $urandom_range(0, 5) == 0) begin
            stall_left     = $urandom_range(1, 10) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : rsp_checker
      sched_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         status_seen[rsp_chan.status]++;
         if (rsp_chan.sweep_down != last_down) dir_changes++;
         last_down = rsp_chan.sweep_down;
         if (expected_rsp.size() == 0) begin
            $error("response beat with nothing expected: status %0d track %0d id %0d",
                   rsp_chan.status, rsp_chan.issued_track, rsp_chan.issued_id);
            err_count++;
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_chan.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_chan.status);
               err_count++;
            end
            if (rsp_chan.issued_track !== want.track) begin
               $error("issued_track: expected %0d, got %0d", want.track,
                      rsp_chan.issued_track);
               err_count++;
            end
            if (rsp_chan.issued_id !== want.id) begin
               $error("issued_id: expected %0d, got %0d", want.id, rsp_chan.issued_id);
               err_count++;
            end
            if (rsp_chan.sweep_down !== want.down) begin
               $error("sweep_down: expected %0d, got %0d", want.down, rsp_chan.sweep_down);
               err_count++;
            end
         end
      end
   end

   // ---------------- tests ----------------
   task automatic test_empty_issue();
      issue_req(0);
      issue_req(16'hFFFF);
   endtask

   task automatic test_field_extremes();
      add_req(0, 16'hFFFF);
      add_req(16'hFFFF, 0);
      add_req(16'h8000, 16'h5555);
      issue_req(0);          // swaps sets, nearest is track 0
      issue_req(16'hFFFF);   // exactly at the head
      issue_req(16'hFFFF);   // nothing above: turn around
   endtask

   task automatic test_ties();
      add_req(100, 7);
      add_req(100, 3);
      add_req(100, 3);       // same track and id: lower slot goes first
      add_req(90, 1);
      add_req(110, 2);
      repeat (4) issue_req(100);
      issue_req(100);        // only 110 left, turns back up
   endtask

   task automatic test_set_swap();
      add_req(500, 1);
      add_req(800, 2);
      issue_req(400);        // swap, serve 500
      add_req(450, 3);       // lands in the pending set
      add_req(600, 4);
      issue_req(500);        // still 800 from the old batch
      issue_req(800);        // new batch after swap
      issue_req(600);
   endtask

   task automatic test_store_full();
      while (stored_count() > 0) issue_req($urandom);
      repeat (fds_pkg::QUEUE_DEPTH) add_req($urandom, $urandom);
      add_req($urandom, $urandom);
      add_req(16'hFFFF, 16'hFFFF);
      issue_req($urandom);
      add_req($urandom, $urandom);   // one slot free again
      repeat (fds_pkg::QUEUE_DEPTH + 1) issue_req($urandom);
   endtask

   task automatic test_backpressure();
      rsp_hold_req = 300;
      repeat (8) send_beat(random_beat(60, 1'b0), 0);
   endtask

   task automatic test_random(input int count);
      int sent;
      int span;
      int add_pct;
      bit tight;
      bit quiet;
      sent = 0;
      while (sent < count) begin
         span         = $urandom_range(10, 60);
         cluster_base = fds_pkg::TRACK_BITS'($urandom);
         tight        = ($urandom_range(0, 2) == 0);
         quiet        = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 2))
            0:       add_pct = 80;
            1:       add_pct = 25;
            default: add_pct = 50;
         endcase
         // the last stretch runs at full rate on both sides
         if (sent > count - 200) idle_en = 1'b0;
         for (int i = 0; i < span && sent < count; i++) begin
            send_beat(random_beat(add_pct, tight), quiet ? 0 : next_gap());
            sent++;
         end
      end
   endtask

   initial begin
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.req_type   = fds_pkg::REQ_ADD;
      req_chan.req_track  = '0;
      req_chan.req_id     = '0;
      req_chan.head_track = '0;
      err_count           = 0;
      cycle_count         = 0;
      dir_changes         = 0;
      last_down           = 1'b0;
      idle_en             = 1'b1;
      rsp_hold_req        = 0;
      cluster_base        = '0;
      last_added_track    = '0;
      live_group          = 1'b0;
      sweeping_down       = 1'b0;
      for (int i = 0; i < 4; i++) status_seen[i] = 0;
      for (int i = 0; i < fds_pkg::QUEUE_DEPTH; i++) begin
         slot_trk[i]   = '0;
         slot_tag[i]   = '0;
         slot_held[i]  = 1'b0;
         slot_group[i] = 1'b0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_issue();
      test_field_extremes();
      test_ties();
      test_set_swap();
      test_store_full();
      test_backpressure();
      test_random(RANDOM_BEATS);
      drain_results();

      $display("Run summary: %0d added, %0d issued, %0d empty, %0d dropped beats checked",
               status_seen[fds_pkg::RSP_ADDED], status_seen[fds_pkg::RSP_ISSUED],
               status_seen[fds_pkg::RSP_EMPTY], status_seen[fds_pkg::RSP_DROPPED]);
      $display("Sweep direction changed %0d times; %0d mismatches", dir_changes, err_count);
      if (err_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
